// ===== hdl/rsta_pkg.sv =====
// ----------------------------------------------------------------------------
// rsta_pkg: shared definitions for the raster scan trace averager
// Sizes, register codes, controller states and the beat structs of the item
// and result channels.
// ----------------------------------------------------------------------------
package rsta_pkg;

  // Store and sample sizes.
  localparam int MAX_RECORD  = 1024;
  localparam int ADDR_W      = $clog2(MAX_RECORD);
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_SHOTS   = 1023;
  localparam int SHOT_W      = 10;
  localparam int SUM_W       = SAMPLE_BITS + SHOT_W;
  localparam int DIV_W       = SUM_W + 1;
  localparam int POS_W       = 8;
  localparam int CNT_W       = POS_W + 1;
  localparam int RLEN_W      = 11;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic signed [DIV_W-1:0] AVG_MAX = DIV_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [DIV_W-1:0] AVG_MIN = DIV_W'(-(1 << (SAMPLE_BITS - 1)));

  // Register reset values.
  localparam logic [SHOT_W-1:0] SHOTS_RESET  = SHOT_W'(10);
  localparam logic [CNT_W-1:0]  COUNT_RESET  = CNT_W'(20);
  localparam logic [RLEN_W-1:0] RECORD_RESET = RLEN_W'(500);

  // Register index, taken from the word address of the configuration port.
  typedef enum logic [2:0] {
    REG_SHOTS         = 3'd0,
    REG_X_COUNT       = 3'd1,
    REG_Y_COUNT       = 3'd2,
    REG_Z_COUNT       = 3'd3,
    REG_RECORD_LENGTH = 3'd4
  } reg_index_t;

  // Request codes of the item channel.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          trace_end;
    logic [9:0]                    flush_index;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [9:0]                    sample_index;
    logic [POS_W-1:0]              x_index;
    logic [POS_W-1:0]              y_index;
    logic [POS_W-1:0]              z_index;
    logic                          point_done;
    logic                          partial;
    logic                          scan_done;
  } result_t;

endpackage

// ===== hdl/rsta_ram.sv =====
// ----------------------------------------------------------------------------
// rsta_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rsta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rsta_div.sv =====
// ----------------------------------------------------------------------------
// rsta_div: iterative signed-by-unsigned divider
// Restoring division on the magnitude, one quotient bit per cycle, with the
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rsta_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [rsta_pkg::DIV_W-1:0]  dividend,
  input  logic [rsta_pkg::SHOT_W-1:0]        divisor,
  output logic                           done,
  output logic signed [rsta_pkg::DIV_W-1:0]  quotient
);
  import rsta_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic                running;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_W-1:0]    mag;
  logic [SHOT_W-1:0]   rem;
  logic [SHOT_W-1:0]   dsr;
  logic                neg;
  logic [SHOT_W:0]     trial;
  logic                fits;

  always_comb begin
    trial = {rem, mag[DIV_W-1]};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_BITS'(DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIV_W-1];
      mag <= dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      if (fits) begin
        rem <= SHOT_W'(trial - {1'b0, dsr});
        mag <= {mag[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[SHOT_W-1:0];
        mag <= {mag[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? $signed(~mag + 1'b1) : $signed(mag);

endmodule

// ===== hdl/raster_scan_trace_averager.sv =====
// ----------------------------------------------------------------------------
// raster_scan_trace_averager: coherent trace averager over an x/y/z scan
// Sums scope traces into a one-trace store and streams out the per-sample
// averages of each scan point, with flush reads of partial averages.
// ----------------------------------------------------------------------------
// The running sums of one trace live in a 1024-entry synchronous RAM that is
// read, updated and written back for every kept sample. Right after reset the
// block runs a clearing pass over that RAM, one entry per cycle, so item
// beats are stalled until the pass is over; configuration writes are taken
// throughout. Items are handled one at a time. A sample that is dropped (past
// the record length, or after the scan is done) is accepted without starting a
// job. A sample of a non-final shot has its RAM read at its beat and then the
// add and write-back in the calculation state. A sample of the final shot of
// a point, and a flush, also divide the sum by the shot count in an iterative
// divider that makes one quotient bit per cycle over 27 bits, and the next
// beat is stalled until its result is loaded. Results sit in an output
// register, and the next item is accepted while a result waits there. The
// scan position advances x first, then y, then z, at the end of the final
// trace of each point, and averages are truncated toward zero and saturated
// to the 16-bit sample range.
// ----------------------------------------------------------------------------
module raster_scan_trace_averager (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rsta_pkg::PADDR_W-1:0]      paddr,
  input  logic [rsta_pkg::PDATA_W-1:0]      pwdata,
  output logic [rsta_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // Item channel
  input  logic                              item_valid,
  output logic                              item_stall,
  input  rsta_pkg::item_t                   item,
  // Result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output rsta_pkg::result_t                 result
);
  import rsta_pkg::*;

  // Configuration registers.
  logic [SHOT_W-1:0] shots_per_point;
  logic [CNT_W-1:0]  x_point_count;
  logic [CNT_W-1:0]  y_point_count;
  logic [CNT_W-1:0]  z_point_count;
  logic [RLEN_W-1:0] record_length;
  logic              cfg_write;

  // Scan state.
  logic [ADDR_W-1:0] sample_position;
  logic [SHOT_W-1:0] shots_done;
  logic [POS_W-1:0]  x_position;
  logic [POS_W-1:0]  y_position;
  logic [POS_W-1:0]  z_position;
  logic              all_points_done;

  // Clearing pass.
  logic              clearing;
  logic [ADDR_W-1:0] clear_addr;

  // Controller.
  state_t state;
  state_t state_next;

  // Register values with out-of-range codes folded in.
  logic [SHOT_W-1:0] spp_eff;
  logic [RLEN_W-1:0] rl_eff;
  logic [CNT_W-1:0]  xc_eff;
  logic [CNT_W-1:0]  yc_eff;
  logic [CNT_W-1:0]  zc_eff;

  logic              accept;
  logic              is_flush;
  logic              step;
  logic              start_job;
  logic              last_shot;
  logic              in_range;
  logic              point_adv;
  logic [CNT_W-1:0]  x_inc;
  logic [CNT_W-1:0]  y_inc;
  logic [CNT_W-1:0]  z_inc;
  logic              x_wrap;
  logic              y_wrap;
  logic              z_wrap;
  logic              scan_next;
  logic [ADDR_W-1:0] read_addr;

  // Item held while it is worked on.
  logic                          job_flush;
  logic                          job_final;
  logic [ADDR_W-1:0]             job_idx;
  logic signed [SAMPLE_BITS-1:0] job_sample;
  logic [POS_W-1:0]              job_x;
  logic [POS_W-1:0]              job_y;
  logic [POS_W-1:0]              job_z;
  logic                          job_point_done;
  logic                          job_scan_done;
  logic [SHOT_W-1:0]             job_divisor;

  // Store access and arithmetic.
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [SUM_W-1:0]        ram_wdata;
  logic [SUM_W-1:0]        ram_rdata;
  logic signed [DIV_W-1:0] new_sum;
  logic                    div_start;
  logic                    div_done;
  logic signed [DIV_W-1:0] quotient;
  logic signed [DIV_W-1:0] avg_sat;
  logic                    load_result;

  // --------------------------------------------------------------------------
  // Configuration port. Writes land in the access phase; pready is tied high.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shots_per_point <= SHOTS_RESET;
      x_point_count   <= COUNT_RESET;
      y_point_count   <= COUNT_RESET;
      z_point_count   <= COUNT_RESET;
      record_length   <= RECORD_RESET;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_SHOTS:         shots_per_point <= pwdata[SHOT_W-1:0];
        REG_X_COUNT:       x_point_count   <= pwdata[CNT_W-1:0];
        REG_Y_COUNT:       y_point_count   <= pwdata[CNT_W-1:0];
        REG_Z_COUNT:       z_point_count   <= pwdata[CNT_W-1:0];
        REG_RECORD_LENGTH: record_length   <= pwdata[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SHOTS:         prdata = PDATA_W'(shots_per_point);
      REG_X_COUNT:       prdata = PDATA_W'(x_point_count);
      REG_Y_COUNT:       prdata = PDATA_W'(y_point_count);
      REG_Z_COUNT:       prdata = PDATA_W'(z_point_count);
      REG_RECORD_LENGTH: prdata = PDATA_W'(record_length);
      default:           prdata = '0;
    endcase
  end

  // A zero register acts as one; larger values clamp to what the store and
  // the position counters can hold.
  always_comb begin
    spp_eff = (shots_per_point == '0) ? SHOT_W'(1) :
              ((32'(shots_per_point) > MAX_SHOTS) ? SHOT_W'(MAX_SHOTS) : shots_per_point);
    rl_eff  = (record_length == '0) ? RLEN_W'(1) :
              ((32'(record_length) > MAX_RECORD) ? RLEN_W'(MAX_RECORD) : record_length);
    xc_eff  = (x_point_count == '0) ? CNT_W'(1) :
              ((x_point_count > CNT_W'(1 << POS_W)) ? CNT_W'(1 << POS_W) : x_point_count);
    yc_eff  = (y_point_count == '0) ? CNT_W'(1) :
              ((y_point_count > CNT_W'(1 << POS_W)) ? CNT_W'(1 << POS_W) : y_point_count);
    zc_eff  = (z_point_count == '0) ? CNT_W'(1) :
              ((z_point_count > CNT_W'(1 << POS_W)) ? CNT_W'(1 << POS_W) : z_point_count);
  end

  // --------------------------------------------------------------------------
  // Clearing pass: zero every entry of the sum store after reset.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == ADDR_W'(MAX_RECORD - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Beat decode. The scan position is updated at the item's beat; the values
  // the result needs are captured alongside it.
  // --------------------------------------------------------------------------
  assign item_stall = clearing || (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_flush   = (item.req_type == REQ_FLUSH);

  always_comb begin
    last_shot = ({1'b0, shots_done} + 1'b1) >= {1'b0, spp_eff};
    in_range  = RLEN_W'(sample_position) < rl_eff;
    step      = accept && !is_flush && !all_points_done;
    start_job = accept && (is_flush || (!all_points_done && in_range));
    point_adv = step && item.trace_end && last_shot;
    x_inc     = {1'b0, x_position} + 1'b1;
    y_inc     = {1'b0, y_position} + 1'b1;
    z_inc     = {1'b0, z_position} + 1'b1;
    x_wrap    = x_inc >= xc_eff;
    y_wrap    = y_inc >= yc_eff;
    z_wrap    = z_inc >= zc_eff;
    scan_next = all_points_done || (point_adv && x_wrap && y_wrap && z_wrap);
    read_addr = is_flush ? item.flush_index[ADDR_W-1:0] : sample_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_position <= '0;
      shots_done      <= '0;
      x_position      <= '0;
      y_position      <= '0;
      z_position      <= '0;
      all_points_done <= 1'b0;
    end else if (step) begin
      if (item.trace_end) begin
        sample_position <= '0;
        if (last_shot) begin
          shots_done <= '0;
          if (!x_wrap) begin
            x_position <= x_inc[POS_W-1:0];
          end else begin
            x_position <= '0;
            if (!y_wrap) begin
              y_position <= y_inc[POS_W-1:0];
            end else begin
              y_position <= '0;
              if (!z_wrap) begin
                z_position <= z_inc[POS_W-1:0];
              end else begin
                z_position      <= '0;
                all_points_done <= 1'b1;
              end
            end
          end
        end else begin
          shots_done <= shots_done + 1'b1;
        end
      end else if (sample_position != ADDR_W'(MAX_RECORD - 1)) begin
        sample_position <= sample_position + 1'b1;
      end
    end
  end

  // A flush with no finished trace returns the raw sum, which is a divide
  // by one.
  always_ff @(posedge clk) begin
    if (start_job) begin
      job_flush      <= is_flush;
      job_final      <= last_shot;
      job_idx        <= read_addr;
      job_sample     <= item.sample;
      job_x          <= x_position;
      job_y          <= y_position;
      job_z          <= z_position;
      job_point_done <= !is_flush && item.trace_end;
      job_scan_done  <= is_flush ? all_points_done : scan_next;
      job_divisor    <= is_flush ? ((shots_done == '0) ? SHOT_W'(1) : shots_done) : spp_eff;
    end
  end

  // --------------------------------------------------------------------------
  // Sum store. Only one item is in flight, so a write-back always lands
  // before the next read of the same entry.
  // --------------------------------------------------------------------------
  rsta_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_RECORD)
  ) u_sum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (read_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    new_sum = {ram_rdata[SUM_W-1], ram_rdata};
    if (!job_flush) begin
      new_sum = new_sum + {{(DIV_W - SAMPLE_BITS){job_sample[SAMPLE_BITS-1]}}, job_sample};
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_CALC) && !job_flush;
      ram_waddr = job_idx;
      ram_wdata = job_final ? '0 : new_sum[SUM_W-1:0];
    end
  end

  assign div_start = (state == ST_CALC) && (job_flush || job_final);

  rsta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (job_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // --------------------------------------------------------------------------
  // Controller.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start_job) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = div_start ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_comb begin
    if (quotient > AVG_MAX) begin
      avg_sat = AVG_MAX;
    end else if (quotient < AVG_MIN) begin
      avg_sat = AVG_MIN;
    end else begin
      avg_sat = quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.average      <= avg_sat[SAMPLE_BITS-1:0];
      result.sample_index <= 10'(job_idx);
      result.x_index      <= job_x;
      result.y_index      <= job_y;
      result.z_index      <= job_z;
      result.point_done   <= job_point_done && !job_flush;
      result.partial      <= job_flush;
      result.scan_done    <= job_scan_done;
    end
  end

endmodule
